// ----- design/ahss_pkg.sv -----
package ahss_pkg;

   localparam int unsigned DEF_MAX_PARTIALS      = 16;
   localparam int unsigned DEF_CORDIC_ITERATIONS = 24;
   localparam int unsigned DEF_PHASE_BITS        = 32;

   localparam int unsigned SAMPLE_W   = 34;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned COUNT_W     = 5;
   localparam int unsigned PART_W      = 5;
   localparam int unsigned STEP_W      = 5;

   localparam logic [CSR_INDEX_W-1:0] REG_BASE_INCREMENT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HARMONIC_MODE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PARTIAL_COUNT  = 2'd2;

   localparam logic [31:0] RST_BASE_INCREMENT = 32'd19685267;
   localparam logic [COUNT_W-1:0] RST_PARTIAL_COUNT = 5'd10;

   // datapath operations
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_LOAD  = 3'd2;
   localparam logic [2:0] OP_ITER  = 3'd3;
   localparam logic [2:0] OP_ROUND = 3'd4;
   localparam logic [2:0] OP_MULT  = 3'd5;
   localparam logic [2:0] OP_ACC   = 3'd6;
   localparam logic [2:0] OP_EMIT  = 3'd7;

   typedef struct packed {
      logic [2:0]        op;
      logic              clear;
      logic [PART_W-1:0] part;
      logic [STEP_W-1:0] step;
   } cmd_type;

   // round(K * 2^40)
   localparam logic signed [43:0] CORDIC_X0 = 44'sd667681663043;

   function automatic logic [31:0] atan_turns(input logic [STEP_W-1:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

// ----- design/ahss_ctrl.sv -----
module ahss_ctrl
   import ahss_pkg::*;
#(
   parameter int unsigned MAX_PARTIALS      = DEF_MAX_PARTIALS,
   parameter int unsigned CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_clear_phases,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [COUNT_W-1:0] partial_count,
   output cmd_type            cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_ITER  = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_MULT  = 3'd4;
   localparam logic [2:0] ST_ACC   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   localparam logic [5:0] MAX_N = 6'(MAX_PARTIALS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_ITERATIONS - 1);

   logic [2:0]        state_ff, state_in;
   logic [PART_W-1:0] part_ff, part_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [5:0]        n_parts;
   logic              accept;

   assign n_parts   = ({1'b0, partial_count} > MAX_N) ? MAX_N : {1'b0, partial_count};
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      part_in      = part_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '{op: OP_NONE, clear: req_clear_phases, part: part_ff, step: step_ff};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.op  = OP_START;
               part_in = '0;
               state_in = (n_parts == 6'd0) ? ST_FIN : ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.op   = OP_LOAD;
            step_in  = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            cmd.op = OP_ITER;
            if (step_ff == LAST_STEP) begin
               state_in = ST_ROUND;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_ROUND: begin
            cmd.op   = OP_ROUND;
            state_in = ST_MULT;
         end
         ST_MULT: begin
            cmd.op   = OP_MULT;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op = OP_ACC;
            if ({1'b0, part_ff} == n_parts - 6'd1) begin
               state_in = ST_FIN;
            end else begin
               part_in  = part_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         part_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         part_ff      <= part_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/ahss_datapath.sv -----
module ahss_datapath
   import ahss_pkg::*;
#(
   parameter int unsigned MAX_PARTIALS = DEF_MAX_PARTIALS,
   parameter int unsigned PHASE_BITS   = DEF_PHASE_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   input  logic [31:0]                base_increment,
   input  logic                       harmonic_mode,
   output logic signed [SAMPLE_W-1:0] rsp_sample
);

   localparam int unsigned GAIN_DEPTH = 2 * MAX_PARTIALS;
   localparam int unsigned KW = $clog2(GAIN_DEPTH);
   localparam int unsigned PW = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
   localparam int unsigned SUM_W = 38;

   logic [PHASE_BITS-1:0] phase_ff [MAX_PARTIALS];
   logic [31:0]           gain_rom [GAIN_DEPTH];

   for (genvar j = 0; j < GAIN_DEPTH; j++) begin : g_gain
      localparam longint unsigned GQ = ((64'd4294967296 / (j + 1)) + 64'd1) >> 1;
      localparam logic [31:0] GV = (GQ > 64'h7FFFFFFF) ? 32'h7FFFFFFF : 32'(GQ);
      assign gain_rom[j] = GV;
   end

   logic signed [43:0]           x_ff, y_ff;
   logic signed [33:0]           z_ff;
   logic [PHASE_BITS-1:0]        inc_ff;
   logic [31:0]                  gain_ff;
   logic signed [31:0]           sine_ff;
   logic signed [63:0]           prod_ff;
   logic signed [SUM_W-1:0]      sum_ff;
   logic signed [SAMPLE_W-1:0]   sample_ff;

   logic [PW-1:0]         pidx;
   logic [KW-1:0]         pk, k, kidx;
   logic [31:0]           ang, mir;
   logic [1:0]            quad;
   logic [KW+PHASE_BITS-1:0] step_prod;
   logic signed [43:0]    x_sh, y_sh;
   logic [31:0]           at;
   logic signed [43:0]    y_rnd;
   logic signed [34:0]    y_q;
   logic signed [31:0]    sine_sat;
   logic signed [63:0]    prod_rnd;
   logic signed [32:0]    term;
   logic signed [SAMPLE_W-1:0] sum_sat;

   assign pidx = cmd.part[PW-1:0];
   assign pk   = KW'(cmd.part);
   assign k    = harmonic_mode ? ((pk << 1) + 1'b1) : (pk + 1'b1);
   assign kidx = k - 1'b1;

   assign ang  = 32'(phase_ff[pidx]) << (32 - PHASE_BITS);
   assign quad = ang[31:30];
   // mirror second and third quadrants about a quarter turn
   assign mir  = (quad == 2'd1 || quad == 2'd2) ? (32'h80000000 - ang) : ang;
   assign step_prod = k * base_increment[PHASE_BITS-1:0];

   assign x_sh = x_ff >>> cmd.step;
   assign y_sh = y_ff >>> cmd.step;
   assign at   = atan_turns(cmd.step);

   assign y_rnd = y_ff + 44'sd256;
   assign y_q   = 35'(y_rnd >>> 9);
   assign sine_sat = (y_q > 35'sd2147483647) ? 32'sh7FFFFFFF :
                     (y_q < -35'sd2147483648) ? 32'sh80000000 : 32'(y_q);

   assign prod_rnd = prod_ff + 64'sd1073741824;
   assign term     = 33'(prod_rnd >>> 31);

   assign sum_sat = (sum_ff > 38'sd8589934591) ? 34'sh1FFFFFFFF :
                    (sum_ff < -38'sd8589934592) ? 34'sh200000000 : SAMPLE_W'(sum_ff);

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_START: begin
            sum_ff <= '0;
         end
         OP_LOAD: begin
            x_ff    <= CORDIC_X0;
            y_ff    <= '0;
            z_ff    <= {{2{mir[31]}}, mir};
            inc_ff  <= step_prod[PHASE_BITS-1:0];
            gain_ff <= gain_rom[kidx];
         end
         OP_ITER: begin
            if (!z_ff[33]) begin
               x_ff <= x_ff - y_sh;
               y_ff <= y_ff + x_sh;
               z_ff <= z_ff - $signed({2'b00, at});
            end else begin
               x_ff <= x_ff + y_sh;
               y_ff <= y_ff - x_sh;
               z_ff <= z_ff + $signed({2'b00, at});
            end
         end
         OP_ROUND: begin
            sine_ff <= sine_sat;
         end
         OP_MULT: begin
            prod_ff <= sine_ff * $signed({1'b0, gain_ff[30:0]});
         end
         OP_ACC: begin
            sum_ff <= sum_ff + SUM_W'(term);
         end
         OP_EMIT: begin
            sample_ff <= sum_sat;
         end
         default: begin
         end
      endcase
   end

   // phase accumulators
   always_ff @(posedge clock) begin
      if (reset || (cmd.op == OP_START && cmd.clear)) begin
         for (int p = 0; p < MAX_PARTIALS; p++) begin
            phase_ff[p] <= '0;
         end
      end else if (cmd.op == OP_ACC) begin
         phase_ff[pidx] <= phase_ff[pidx] + inc_ff;
      end
   end

   assign rsp_sample = sample_ff;

endmodule

// ----- design/additive_harmonic_sine_synth_core.sv -----
// Additive sine synthesiser: each accepted request beat yields one response beat holding
// the sum of up to MAX_PARTIALS harmonic partials, each a CORDIC sine of its phase
// accumulator scaled by 1/k (Q3.31 result). Partials are worked one after another
// through one shared CORDIC unit, each in a load step, the CORDIC iterations, then
// round, multiply and accumulate steps; a beat ends in a finish step that waits for
// the previous response beat to leave the output register. A finished sample waits
// in that register while the next request is taken. Write the csr_ registers only
// while idle.
module additive_harmonic_sine_synth_core
   import ahss_pkg::*;
#(
   parameter int unsigned MAX_PARTIALS      = DEF_MAX_PARTIALS,
   parameter int unsigned CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS,
   parameter int unsigned PHASE_BITS        = DEF_PHASE_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_clear_phases,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data
);

   logic [31:0]        base_increment_ff;
   logic               harmonic_mode_ff;
   logic [COUNT_W-1:0] partial_count_ff;
   cmd_type            cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_increment_ff <= RST_BASE_INCREMENT;
         harmonic_mode_ff  <= 1'b0;
         partial_count_ff  <= RST_PARTIAL_COUNT;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_BASE_INCREMENT: base_increment_ff <= csr_write_data;
            REG_HARMONIC_MODE:  harmonic_mode_ff  <= csr_write_data[0];
            REG_PARTIAL_COUNT:  partial_count_ff  <= csr_write_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ahss_ctrl #(
      .MAX_PARTIALS      (MAX_PARTIALS),
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_clear_phases (req_clear_phases),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .partial_count    (partial_count_ff),
      .cmd              (cmd)
   );

   ahss_datapath #(
      .MAX_PARTIALS (MAX_PARTIALS),
      .PHASE_BITS   (PHASE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .base_increment (base_increment_ff),
      .harmonic_mode  (harmonic_mode_ff),
      .rsp_sample     (rsp_sample)
   );

   // busy right after taking a beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a sample is in work");

   // a new response only comes out of a busy controller
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised while idle");

   // no response the cycle right after an accept unless one was already waiting
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |=> !rsp_valid)
      else $error("response appeared too early");

endmodule
